[hdl/tcsc_pkg.sv]
`default_nettype none
package tcsc_pkg;

    localparam int NAME_CHARS = 15;
    localparam int TEXT_W     = NAME_CHARS * 8;
    localparam int ROM_COUNT  = 16;
    localparam int ACTIVE_W   = 5;
    localparam int CNT32_W    = 32;

    // command codes
    localparam logic [1:0] CMD_CLASSIFY = 2'd0;
    localparam logic [1:0] CMD_SET      = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;
    localparam logic [1:0] CMD_SPARE    = 2'd3;

    // rule action codes
    localparam logic [7:0] ACT_DEMOTE = 8'd1;
    localparam logic [7:0] ACT_BOOST  = 8'd2;
    localparam logic [7:0] ACT_MID    = 8'd3;

    // outcome codes
    localparam logic [2:0] OUT_NONE    = 3'd0;
    localparam logic [2:0] OUT_DEMOTE  = 3'd1;
    localparam logic [2:0] OUT_BOOST   = 3'd2;
    localparam logic [2:0] OUT_MID     = 3'd3;
    localparam logic [2:0] OUT_UNKNOWN = 3'd4;

    // core constants
    localparam logic [2:0] CORE_TOP = 3'd7;
    localparam logic [2:0] CORE_MID = 3'd4;
    localparam logic [2:0] CORE_LOW = 3'd3;

    // token handed from cell to cell
    typedef struct packed {
        logic       valid;
        logic       hit;
        logic [7:0] act;
        logic       eq_hit;
        logic       free_hit;
    } tok_t;

    // fixed pattern table, char 0 in the low byte
    function automatic logic [TEXT_W-1:0] rom_pat(input logic [3:0] idx);
        logic [TEXT_W-1:0] p;
        case (idx)
            4'd0:    p = TEXT_W'(64'h6b6f6f6265636166);
            4'd1:    p = TEXT_W'(48'h616e6174616b);
            4'd2:    p = TEXT_W'(32'h6163726f);
            4'd3:    p = TEXT_W'(72'h6d6172676174736e69);
            4'd4:    p = TEXT_W'(48'h6b6f746b6974);
            4'd5:    p = TEXT_W'(56'h6f61696c69687a);
            4'd6:    p = TEXT_W'(72'h7061706c6c6177696d);
            4'd7:    p = TEXT_W'(80'h72657075536874726165);
            4'd8:    p = TEXT_W'(40'h616d616c6c);
            4'd9:    p = TEXT_W'(32'h6e657771);
            4'd10:   p = TEXT_W'(64'h726f747563657865);
            4'd11:   p = TEXT_W'(80'h746163696c707061796d);
            4'd12:   p = TEXT_W'(24'h6f6568);
            4'd13:   p = TEXT_W'(72'h6c6665636166727573);
            4'd14:   p = TEXT_W'(88'h61657268547265646e6552);
            4'd15:   p = TEXT_W'(80'h732d7265736f706d6f63);
            default: p = '0;
        endcase
        return p;
    endfunction

    // zero-filled text from the two name words
    function automatic logic [TEXT_W-1:0] unpack_text(input logic [63:0] lo,
                                                      input logic [55:0] hi);
        logic [TEXT_W-1:0] raw;
        logic [TEXT_W-1:0] t;
        logic              ended;
        raw   = {hi, lo};
        t     = '0;
        ended = 1'b0;
        for (int i = 0; i < NAME_CHARS; i++) begin
            if (raw[i*8 +: 8] == 8'd0) ended = 1'b1;
            if (!ended) t[i*8 +: 8] = raw[i*8 +: 8];
        end
        return t;
    endfunction

    // non-empty pattern occurs somewhere in text
    function automatic logic has_sub(input logic [TEXT_W-1:0] txt,
                                     input logic [TEXT_W-1:0] pat);
        logic any;
        logic ok;
        any = 1'b0;
        for (int s = 0; s < NAME_CHARS; s++) begin
            ok = 1'b1;
            for (int j = 0; j < NAME_CHARS; j++) begin
                if (pat[j*8 +: 8] != 8'd0) begin
                    if (s + j >= NAME_CHARS) ok = 1'b0;
                    else if (txt[(s+j)*8 +: 8] != pat[j*8 +: 8]) ok = 1'b0;
                end
            end
            any = any | ok;
        end
        return any & (pat[7:0] != 8'd0);
    endfunction

    function automatic logic [2:0] mod3(input logic [2:0] c);
        logic [2:0] r;
        case (c)
            3'd0, 3'd3, 3'd6: r = 3'd0;
            3'd1, 3'd4, 3'd7: r = 3'd1;
            default:          r = 3'd2;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/tcsc_cell.sv]
`default_nettype none
module tcsc_cell #(
    parameter int CNT_W = 5
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  tcsc_pkg::tok_t               tok_i,
    input  wire [CNT_W-1:0]              cnt_i,
    input  wire [tcsc_pkg::TEXT_W-1:0]   text,
    input  wire [7:0]                    action,
    input  wire                          wr_en,
    input  wire                          wr_use_eq,
    input  wire                          clr,
    output tcsc_pkg::tok_t               tok_o,
    output logic [CNT_W-1:0]             cnt_o
);

    logic [tcsc_pkg::TEXT_W-1:0] pat_reg;
    logic [7:0]                  act_reg;
    logic                        en_reg;
    logic                        eqsel_reg, eqsel_next;
    logic                        freesel_reg, freesel_next;
    tcsc_pkg::tok_t              tok_reg, tok_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        my_hit, my_eq, my_free, sel;

    // local match against the broadcast text
    always_comb begin
        my_hit  = en_reg & tcsc_pkg::has_sub(text, pat_reg);
        my_eq   = en_reg & (pat_reg == text);
        my_free = ~en_reg;
        tok_next          = tok_i;
        tok_next.hit      = tok_i.hit | my_hit;
        tok_next.act      = tok_i.hit ? tok_i.act : act_reg;
        tok_next.eq_hit   = tok_i.eq_hit | my_eq;
        tok_next.free_hit = tok_i.free_hit | my_free;
        eqsel_next        = my_eq & ~tok_i.eq_hit;
        freesel_next      = my_free & ~tok_i.free_hit;
        cnt_next          = cnt_i + CNT_W'(en_reg);
        sel               = wr_use_eq ? eqsel_reg : freesel_reg;
    end

    // token stage and slot selection marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg     <= '0;
            eqsel_reg   <= 1'b0;
            freesel_reg <= 1'b0;
        end else begin
            tok_reg <= tok_i.valid ? tok_next : '0;
            if (tok_i.valid) begin
                eqsel_reg   <= eqsel_next;
                freesel_reg <= freesel_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
    end

    // rule storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg <= 1'b0;
        end else if (clr) begin
            en_reg <= 1'b0;
        end else if (wr_en && sel) begin
            en_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && sel) begin
            pat_reg <= text;
            act_reg <= action;
        end
    end

    assign tok_o = tok_reg;
    assign cnt_o = cnt_reg;

endmodule
`default_nettype wire

[hdl/task_core_steering_classifier_unit.sv]
`default_nettype none
// flow: the request is captured, its token walks the rule cells, the tail token is held, then the result
// is written to the output register; no new request is taken until then
// a new request is taken while the previous result still waits in the output register
// reset: aresetn synchronous active low, clears rules enabled, counters and control
module task_core_steering_classifier_unit #(
    parameter int RULE_SLOTS = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // command, name_low, name_high, proposed_core, rule_action
    input  wire [135:0]  s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // chosen_core, outcome, status, steered_total, demote_total, boost_total,
    // mid_total, rule_count
    output logic [143:0] m_tdata
);

    localparam int CNT_W = $clog2(RULE_SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic                        accept, fire;
    logic                        start_reg;
    logic [1:0]                  cmd_reg;
    logic [tcsc_pkg::TEXT_W-1:0] text_reg;
    logic [2:0]                  core_reg;
    logic [7:0]                  action_reg;
    logic [2:0]                  rom_grp_reg;
    tcsc_pkg::tok_t              tail_reg;
    logic [CNT_W-1:0]            tail_cnt_reg;
    tcsc_pkg::tok_t              tok [RULE_SLOTS+1];
    logic [CNT_W-1:0]            cnt [RULE_SLOTS+1];
    logic [15:0]                 rom_hit;
    logic                        wr_en, clr;
    logic [31:0]                 steer_reg, demote_reg, boost_reg, mid_reg;
    logic [31:0]                 steer_next, demote_next, boost_next, mid_next;
    logic [2:0]                  chosen_next, outcome_next;
    logic                        status_next;
    logic [CNT_W-1:0]            active_next;
    logic                        m_tvalid_reg;
    logic [143:0]                m_tdata_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign fire     = (state_reg == ST_DONE) & (~m_tvalid_reg | m_tready);

    // request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= s_tdata[1:0];
            text_reg   <= tcsc_pkg::unpack_text(s_tdata[65:2], s_tdata[121:66]);
            core_reg   <= s_tdata[124:122];
            action_reg <= s_tdata[132:125];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) start_reg <= 1'b0;
        else          start_reg <= accept;
    end

    // fixed pattern groups, registered per group
    always_comb begin
        for (int k = 0; k < tcsc_pkg::ROM_COUNT; k++) begin
            rom_hit[k] = tcsc_pkg::has_sub(text_reg, tcsc_pkg::rom_pat(4'(k)));
        end
    end

    always_ff @(posedge aclk) begin
        rom_grp_reg <= {|rom_hit[15:11], |rom_hit[10:8], |rom_hit[7:0]};
    end

    // rule cell chain
    assign tok[0] = '{valid: start_reg, hit: 1'b0, act: 8'd0, eq_hit: 1'b0, free_hit: 1'b0};
    assign cnt[0] = '0;
    assign wr_en  = fire & (cmd_reg == tcsc_pkg::CMD_SET) & (tail_reg.eq_hit | tail_reg.free_hit);
    assign clr    = fire & (cmd_reg == tcsc_pkg::CMD_CLEAR);

    for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
        tcsc_cell #(.CNT_W(CNT_W)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .tok_i     (tok[g]),
            .cnt_i     (cnt[g]),
            .text      (text_reg),
            .action    (action_reg),
            .wr_en     (wr_en),
            .wr_use_eq (tail_reg.eq_hit),
            .clr       (clr),
            .tok_o     (tok[g+1]),
            .cnt_o     (cnt[g+1])
        );
    end

    // control
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SCAN;
            ST_SCAN: if (tok[RULE_SLOTS].valid) state_next = ST_DONE;
            ST_DONE: if (fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tail_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SCAN && tok[RULE_SLOTS].valid) tail_reg <= tok[RULE_SLOTS];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN && tok[RULE_SLOTS].valid) tail_cnt_reg <= cnt[RULE_SLOTS];
    end

    // result decision
    always_comb begin
        chosen_next  = core_reg;
        outcome_next = tcsc_pkg::OUT_NONE;
        status_next  = 1'b0;
        active_next  = tail_cnt_reg;
        steer_next   = steer_reg;
        demote_next  = demote_reg;
        boost_next   = boost_reg;
        mid_next     = mid_reg;
        case (cmd_reg)
            tcsc_pkg::CMD_CLASSIFY: begin
                if (tail_reg.hit) begin
                    steer_next = steer_reg + 32'd1;
                    case (tail_reg.act)
                        tcsc_pkg::ACT_DEMOTE: begin
                            chosen_next  = tcsc_pkg::mod3(core_reg);
                            outcome_next = tcsc_pkg::OUT_DEMOTE;
                            demote_next  = demote_reg + 32'd1;
                        end
                        tcsc_pkg::ACT_BOOST: begin
                            chosen_next  = tcsc_pkg::CORE_TOP;
                            outcome_next = tcsc_pkg::OUT_BOOST;
                            boost_next   = boost_reg + 32'd1;
                        end
                        tcsc_pkg::ACT_MID: begin
                            chosen_next  = tcsc_pkg::CORE_MID + tcsc_pkg::mod3(core_reg);
                            outcome_next = tcsc_pkg::OUT_MID;
                            mid_next     = mid_reg + 32'd1;
                        end
                        default: outcome_next = tcsc_pkg::OUT_UNKNOWN;
                    endcase
                end else if (rom_grp_reg[0]) begin
                    if (core_reg >= tcsc_pkg::CORE_LOW) begin
                        chosen_next  = tcsc_pkg::mod3(core_reg);
                        outcome_next = tcsc_pkg::OUT_DEMOTE;
                        demote_next  = demote_reg + 32'd1;
                        steer_next   = steer_reg + 32'd1;
                    end
                end else if (rom_grp_reg[1]) begin
                    if (core_reg < tcsc_pkg::CORE_MID || core_reg == tcsc_pkg::CORE_TOP) begin
                        chosen_next  = tcsc_pkg::CORE_MID + tcsc_pkg::mod3(core_reg);
                        outcome_next = tcsc_pkg::OUT_MID;
                        mid_next     = mid_reg + 32'd1;
                        steer_next   = steer_reg + 32'd1;
                    end
                end else if (rom_grp_reg[2]) begin
                    if (core_reg < tcsc_pkg::CORE_MID) begin
                        chosen_next  = tcsc_pkg::CORE_TOP;
                        outcome_next = tcsc_pkg::OUT_BOOST;
                        boost_next   = boost_reg + 32'd1;
                        steer_next   = steer_reg + 32'd1;
                    end
                end
            end
            tcsc_pkg::CMD_SET: begin
                if (!tail_reg.eq_hit) begin
                    if (tail_reg.free_hit) active_next = tail_cnt_reg + CNT_W'(1);
                    else                   status_next = 1'b1;
                end
            end
            tcsc_pkg::CMD_CLEAR: active_next = '0;
            default: ;
        endcase
    end

    // counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steer_reg  <= '0;
            demote_reg <= '0;
            boost_reg  <= '0;
            mid_reg    <= '0;
        end else if (fire) begin
            steer_reg  <= steer_next;
            demote_reg <= demote_next;
            boost_reg  <= boost_next;
            mid_reg    <= mid_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= {4'd0, tcsc_pkg::ACTIVE_W'(active_next), mid_next, boost_next,
                            demote_next, steer_next, status_next, outcome_next, chosen_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

[hdl/tcsc_checker.sv]
`default_nettype none
module tcsc_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [143:0] m_tdata
);

    // no result straight after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a failed set never steers
    a_status_plain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6] |-> m_tdata[5:3] == tcsc_pkg::OUT_NONE)
        else $error("failed set with steering outcome");

    // boost always lands on the top core
    a_boost_core: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5:3] == tcsc_pkg::OUT_BOOST |-> m_tdata[2:0] == tcsc_pkg::CORE_TOP)
        else $error("boost to wrong core");

    // demote always lands on a low core
    a_demote_core: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5:3] == tcsc_pkg::OUT_DEMOTE |-> m_tdata[2:0] < tcsc_pkg::CORE_LOW)
        else $error("demote to wrong core");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind task_core_steering_classifier_unit tcsc_checker u_tcsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

// one result word split into its fields
typedef struct packed {
    logic [2:0]  chosen;
    logic [2:0]  outcome;
    logic        status;
    logic [31:0] steered;
    logic [31:0] demoted;
    logic [31:0] boosted;
    logic [31:0] mid;
    logic [4:0]  active;
} steer_result_t;

// fixed pattern table, char 0 in the low byte
function automatic logic [119:0] fixed_pattern(input int idx);
    case (idx)
        0:       return 120'h6b6f6f6265636166;
        1:       return 120'h616e6174616b;
        2:       return 120'h6163726f;
        3:       return 120'h6d6172676174736e69;
        4:       return 120'h6b6f746b6974;
        5:       return 120'h6f61696c69687a;
        6:       return 120'h7061706c6c6177696d;
        7:       return 120'h72657075536874726165;
        8:       return 120'h616d616c6c;
        9:       return 120'h6e657771;
        10:      return 120'h726f747563657865;
        11:      return 120'h746163696c707061796d;
        12:      return 120'h6f6568;
        13:      return 120'h6c6665636166727573;
        14:      return 120'h61657268547265646e6552;
        default: return 120'h732d7265736f706d6f63;
    endcase
endfunction

function automatic int text_length(input logic [119:0] t);
    int n;
    n = 0;
    while (n < 15 && t[n*8 +: 8] != 8'd0) n++;
    return n;
endfunction

class steering_scoreboard;
    logic [119:0]  pattern [16];
    logic [7:0]    action [16];
    bit            enabled [16];
    logic [31:0]   steered, demoted, boosted, mid;
    steer_result_t pending [$];
    int            errors;
    int            results_seen;
    int            hits;
    int            full_sets;

    function new();
        foreach (enabled[i]) begin
            enabled[i] = 0;
            pattern[i] = '0;
            action[i]  = '0;
        end
        steered = 0; demoted = 0; boosted = 0; mid = 0;
        errors = 0; results_seen = 0; hits = 0; full_sets = 0;
    endfunction

    // zero-filled text, everything past the first zero dropped
    function logic [119:0] name_text(input logic [63:0] lo, input logic [55:0] hi);
        logic [119:0] raw, t;
        raw = {hi, lo};
        t   = '0;
        for (int i = 0; i < 15; i++) begin
            if (raw[i*8 +: 8] == 8'd0) break;
            t[i*8 +: 8] = raw[i*8 +: 8];
        end
        return t;
    endfunction

    function bit contains(input logic [119:0] t, input logic [119:0] p);
        int tl, pl;
        bit ok;
        tl = text_length(t);
        pl = text_length(p);
        if (pl == 0 || pl > tl) return 0;
        for (int s = 0; s + pl <= tl; s++) begin
            ok = 1;
            for (int j = 0; j < pl; j++)
                if (t[(s+j)*8 +: 8] != p[j*8 +: 8]) ok = 0;
            if (ok) return 1;
        end
        return 0;
    endfunction

    // accepted request: update state and queue the expected result
    function void note_request(input logic [1:0] cmd, input logic [63:0] lo,
                               input logic [55:0] hi, input logic [2:0] core,
                               input logic [7:0] act);
        steer_result_t r;
        logic [119:0]  t;
        bit            done;
        int            slot, grp, cnt;
        t = name_text(lo, hi);
        r = '0;
        r.chosen = core;
        r.outcome = tcsc_pkg::OUT_NONE;
        done = 0;
        if (cmd == tcsc_pkg::CMD_CLASSIFY) begin
            for (int i = 0; i < 16; i++) begin
                if (!done && enabled[i] && contains(t, pattern[i])) begin
                    done = 1;
                    steered++;
                    case (action[i])
                        tcsc_pkg::ACT_DEMOTE: begin
                            r.chosen = 3'(core % 3); r.outcome = tcsc_pkg::OUT_DEMOTE;
                            demoted++;
                        end
                        tcsc_pkg::ACT_BOOST: begin
                            r.chosen = tcsc_pkg::CORE_TOP; r.outcome = tcsc_pkg::OUT_BOOST;
                            boosted++;
                        end
                        tcsc_pkg::ACT_MID: begin
                            r.chosen = tcsc_pkg::CORE_MID + 3'(core % 3);
                            r.outcome = tcsc_pkg::OUT_MID;
                            mid++;
                        end
                        default: r.outcome = tcsc_pkg::OUT_UNKNOWN;
                    endcase
                end
            end
            // fixed groups only when no rule took the task
            for (int i = 0; i < 16; i++) begin
                if (!done && contains(t, fixed_pattern(i))) begin
                    done = 1;
                    grp = (i < 8) ? 0 : (i < 11) ? 1 : 2;
                    if (grp == 0 && core >= tcsc_pkg::CORE_LOW) begin
                        r.chosen = 3'(core % 3); r.outcome = tcsc_pkg::OUT_DEMOTE;
                        demoted++; steered++;
                    end else if (grp == 1 &&
                                 (core < tcsc_pkg::CORE_MID || core == tcsc_pkg::CORE_TOP)) begin
                        r.chosen = tcsc_pkg::CORE_MID + 3'(core % 3);
                        r.outcome = tcsc_pkg::OUT_MID;
                        mid++; steered++;
                    end else if (grp == 2 && core < tcsc_pkg::CORE_MID) begin
                        r.chosen = tcsc_pkg::CORE_TOP; r.outcome = tcsc_pkg::OUT_BOOST;
                        boosted++; steered++;
                    end
                end
            end
            if (r.outcome != tcsc_pkg::OUT_NONE) hits++;
        end else if (cmd == tcsc_pkg::CMD_SET) begin
            slot = -1;
            for (int i = 0; i < 16; i++)
                if (slot < 0 && enabled[i] && pattern[i] == t) slot = i;
            for (int i = 0; i < 16; i++)
                if (slot < 0 && !enabled[i]) slot = i;
            if (slot >= 0) begin
                pattern[slot] = t;
                action[slot]  = act;
                enabled[slot] = 1;
            end else begin
                r.status = 1'b1;
                full_sets++;
            end
        end else if (cmd == tcsc_pkg::CMD_CLEAR) begin
            foreach (enabled[i]) begin
                enabled[i] = 0; pattern[i] = '0; action[i] = '0;
            end
        end
        cnt = 0;
        foreach (enabled[i]) cnt += enabled[i];
        r.steered = steered; r.demoted = demoted; r.boosted = boosted; r.mid = mid;
        r.active = 5'(cnt);
        pending.push_back(r);
    endfunction

    function void field_check(input string fname, input logic [31:0] e,
                              input logic [31:0] a, inout bit bad);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, e, a);
            bad = 1;
        end
    endfunction

    function void check_result(input logic [143:0] d);
        steer_result_t e, a;
        bit bad;
        a.chosen  = d[2:0];
        a.outcome = d[5:3];
        a.status  = d[6];
        a.steered = d[38:7];
        a.demoted = d[70:39];
        a.boosted = d[102:71];
        a.mid     = d[134:103];
        a.active  = d[139:135];
        results_seen++;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, d);
            errors++;
            return;
        end
        e = pending.pop_front();
        bad = 0;
        field_check("chosen_core", 32'(e.chosen), 32'(a.chosen), bad);
        field_check("outcome", 32'(e.outcome), 32'(a.outcome), bad);
        field_check("status", 32'(e.status), 32'(a.status), bad);
        field_check("steered_total", e.steered, a.steered, bad);
        field_check("demote_total", e.demoted, a.demoted, bad);
        field_check("boost_total", e.boosted, a.boosted, bad);
        field_check("mid_total", e.mid, a.mid, bad);
        field_check("rule_count", 32'(e.active), 32'(a.active), bad);
        if (bad) errors++;
    endfunction
endclass

module testbench;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 640;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [143:0] m_tdata;

    steering_scoreboard steer_sb = new();
    logic [119:0] rule_pool [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int requests_sent = 0;

    task_core_steering_classifier_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // result side: check and stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) steer_sb.check_result(m_tdata);
        m_tready <= aresetn && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (aresetn) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding",
                         steer_sb.pending.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // drive one request and hold it until taken
    task automatic send_request(input logic [1:0] cmd, input logic [119:0] name,
                                input logic [2:0] core, input logic [7:0] act);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, act, core, name[119:64], name[63:0], cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        steer_sb.note_request(cmd, name[63:0], name[119:64], core, act);
        requests_sent++;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    endtask

    // text of random letters from the first span + 1 letters; a short alphabet makes rules hit often
    function automatic logic [119:0] letters(input int n, input int span);
        logic [119:0] t;
        t = '0;
        for (int i = 0; i < n && i < 15; i++) t[i*8 +: 8] = 8'h61 + 8'($urandom_range(0, span));
        return t;
    endfunction

    function automatic logic [119:0] random_word();
        return 120'({$urandom, $urandom, $urandom, $urandom});
    endfunction

    function automatic logic [119:0] random_pattern();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return '0;
        if (sel == 1) return fixed_pattern($urandom_range(0, 15));
        if (sel == 2) return random_word();
        return letters($urandom_range(1, 4), 3);
    endfunction

    // name made of filler, usually with a known fragment dropped in
    function automatic logic [119:0] random_name();
        logic [119:0] t, frag;
        int sel, len, flen, pos;
        sel = $urandom_range(0, 19);
        if (sel == 0) return random_word();
        if (sel == 1) return '0;
        len = $urandom_range(1, 15);
        t = letters(len, (sel < 5) ? 25 : 3);
        if (sel < 12 || rule_pool.size() == 0) frag = fixed_pattern($urandom_range(0, 15));
        else frag = rule_pool[$urandom_range(0, rule_pool.size() - 1)];
        flen = text_length(frag);
        if (sel != 19 && flen > 0 && flen <= 15) begin
            pos = $urandom_range(0, 15 - flen);
            for (int j = 0; j < flen; j++) t[(pos+j)*8 +: 8] = frag[j*8 +: 8];
            for (int j = 0; j < pos + flen; j++)
                if (t[j*8 +: 8] == 8'd0) t[j*8 +: 8] = 8'h5f;
        end
        // text after an early zero must be ignored
        if ($urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, 14);
            t[pos*8 +: 8] = 8'd0;
            for (int j = pos + 1; j < 15; j++) t[j*8 +: 8] = 8'($urandom_range(1, 255));
        end
        return t;
    endfunction

    task automatic random_request();
        int sel;
        logic [119:0] p;
        logic [7:0] act;
        sel = $urandom_range(0, 99);
        act = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3));
        if (sel < 3) begin
            send_request(tcsc_pkg::CMD_CLEAR, random_word(), 3'($urandom), act);
        end else if (sel < 5) begin
            send_request(tcsc_pkg::CMD_SPARE, random_word(), 3'($urandom), 8'($urandom));
        end else if (sel < 30) begin
            p = random_pattern();
            rule_pool.push_back(p);
            if (rule_pool.size() > 24) void'(rule_pool.pop_front());
            send_request(tcsc_pkg::CMD_SET, p, 3'($urandom), act);
        end else begin
            send_request(tcsc_pkg::CMD_CLASSIFY, random_name(), 3'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        int phase_pct [4][2];
        phase_pct = '{'{0, 0}, '{65, 0}, '{0, 65}, '{36, 36}};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty name, every action kind, update, empty pattern, odd command
        send_request(tcsc_pkg::CMD_CLASSIFY, '0, 3'd7, 8'd0);
        send_request(tcsc_pkg::CMD_SET, letters(2, 0), 3'd5, tcsc_pkg::ACT_DEMOTE);  // "aa"
        send_request(tcsc_pkg::CMD_SET, 120'h6362, 3'd0, tcsc_pkg::ACT_BOOST);       // "bc"
        send_request(tcsc_pkg::CMD_SET, 120'h64, 3'd1, tcsc_pkg::ACT_MID);           // "d"
        send_request(tcsc_pkg::CMD_SET, 120'h7a7a, 3'd2, 8'hff);                     // unknown action
        send_request(tcsc_pkg::CMD_SET, '0, 3'd3, tcsc_pkg::ACT_BOOST);              // empty pattern
        send_request(tcsc_pkg::CMD_CLASSIFY, 120'h61617878, 3'd7, 8'hff);
        send_request(tcsc_pkg::CMD_CLASSIFY, 120'h78636278, 3'd0, 8'd0);
        send_request(tcsc_pkg::CMD_CLASSIFY, 120'h6478, 3'd6, 8'd0);
        send_request(tcsc_pkg::CMD_CLASSIFY, 120'h7a7a, 3'd4, 8'd0);
        send_request(tcsc_pkg::CMD_SET, 120'h6362, 3'd0, tcsc_pkg::ACT_DEMOTE);      // rewrite "bc"
        send_request(tcsc_pkg::CMD_CLASSIFY, 120'h6362, 3'd5, 8'd0);
        // text after zero
        send_request(tcsc_pkg::CMD_CLASSIFY, {{14{8'hff}}, 8'h00}, 3'd7, 8'hff);
        send_request(tcsc_pkg::CMD_SPARE, {120{1'b1}}, 3'd7, 8'hff);
        send_request(tcsc_pkg::CMD_CLASSIFY, fixed_pattern(0), 3'd3, 8'd0);
        send_request(tcsc_pkg::CMD_CLASSIFY, fixed_pattern(3), 3'd2, 8'd0);
        send_request(tcsc_pkg::CMD_CLASSIFY, fixed_pattern(8), 3'd7, 8'd0);
        send_request(tcsc_pkg::CMD_CLASSIFY, fixed_pattern(9), 3'd5, 8'd0);
        send_request(tcsc_pkg::CMD_CLASSIFY, fixed_pattern(14), 3'd0, 8'd0);
        send_request(tcsc_pkg::CMD_CLASSIFY, fixed_pattern(15), 3'd4, 8'd0);
        send_request(tcsc_pkg::CMD_CLEAR, '0, 3'd0, 8'd0);
        send_request(tcsc_pkg::CMD_CLASSIFY, 120'h6161, 3'd6, 8'd0);

        // random traffic in four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = phase_pct[ph][0];
            recv_stall_pct = phase_pct[ph][1];
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) random_request();
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        while (steer_sb.pending.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        $display("sent %0d requests, checked %0d results: %0d steered tasks, %0d sets refused",
                 requests_sent, steer_sb.results_seen, steer_sb.hits, steer_sb.full_sets);
        if (steer_sb.errors == 0 && steer_sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

[filelist.f]
hdl/tcsc_pkg.sv
hdl/tcsc_cell.sv
hdl/task_core_steering_classifier_unit.sv
hdl/tcsc_checker.sv
tb/testbench.sv
